>>> design/two_level_local_branch_predictor_assert.svh
// assertion macros shared by the checker of the local branch predictor
`ifndef TWO_LEVEL_LOCAL_BRANCH_PREDICTOR_ASSERT_SVH
`define TWO_LEVEL_LOCAL_BRANCH_PREDICTOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define TLLBP_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define TLLBP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> design/tllbp_pkg.sv
// shared types and constants of the two-level local branch predictor
`default_nettype none

package tllbp_pkg;

    // pc slicing: low bits pick the pattern table, next bits pick the history
    localparam int TABLE_BITS    = 3;
    localparam int HIDX_BITS     = 9;
    localparam int HIST_BITS_DEF = 6;

    // stream widths
    localparam int PC_W      = 32;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    // request kinds
    localparam logic REQ_PREDICT = 1'b0;
    localparam logic REQ_TRAIN   = 1'b1;

    // counter codes
    localparam logic [1:0] CTR_MIN     = 2'd0;
    localparam logic [1:0] CTR_WEAK_NT = 2'd1;
    localparam logic [1:0] CTR_WEAK_T  = 2'd2;
    localparam logic [1:0] CTR_MAX     = 2'd3;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HIST,
        S_CTR
    } t_state;

    // prediction handed from the controller to the output stage
    typedef struct packed {
        logic valid;
        logic taken;
    } t_res;

endpackage

`default_nettype wire

>>> design/two_level_local_branch_predictor.sv
// two-level local branch predictor: per-branch history selects a 2-bit counter
// one transaction at a time: accept, history read, counter read, then write-back or result
// a prediction passes S_HIST and S_CTR, then enters the output register once that is free
// a held prediction stalls the sequencer only when the next is ready and the held one is not taken
// after reset a clearing pass over 2^max(9, 3+HIST_BITS) addresses (512 by default)
// zeroes histories and sets counters to weak not taken; no request is taken meanwhile
`default_nettype none

module two_level_local_branch_predictor import tllbp_pkg::*; #(
    parameter int HIST_BITS = HIST_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,  // pc[31:0], taken[32], zero pad
    input  wire logic                 i_s_tuser,  // req_type[0]
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic      [M_TDATA_W-1:0] o_m_tdata   // predict_taken[0], zero pad
);

    localparam int CTR_AW = TABLE_BITS + HIST_BITS;

    logic                 hist_we, hist_re;
    logic [HIDX_BITS-1:0] hist_waddr, hist_raddr;
    logic [HIST_BITS-1:0] hist_wdata, hist_rdata;
    logic                 ctr_we, ctr_re;
    logic [CTR_AW-1:0]    ctr_waddr, ctr_raddr;
    logic [1:0]           ctr_wdata, ctr_rdata;
    t_res                 res;
    logic                 res_free;

    // local history table
    tllbp_ram #(
        .WIDTH (HIST_BITS),
        .DEPTH (2**HIDX_BITS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_re    (hist_re),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    // pattern counters of all tables
    tllbp_ram #(
        .WIDTH (2),
        .DEPTH (2**CTR_AW)
    ) u_ctr_ram (
        .i_clk   (i_clk),
        .i_we    (ctr_we),
        .i_waddr (ctr_waddr),
        .i_wdata (ctr_wdata),
        .i_re    (ctr_re),
        .i_raddr (ctr_raddr),
        .o_rdata (ctr_rdata)
    );

    // sequencer
    tllbp_ctrl #(
        .HIST_BITS (HIST_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_s_tvalid),
        .o_req_ready  (o_s_tready),
        .i_req_type   (i_s_tuser),
        .i_pc         (i_s_tdata[PC_W-1:0]),
        .i_dir        (i_s_tdata[PC_W]),
        .o_hist_we    (hist_we),
        .o_hist_waddr (hist_waddr),
        .o_hist_wdata (hist_wdata),
        .o_hist_re    (hist_re),
        .o_hist_raddr (hist_raddr),
        .i_hist_rdata (hist_rdata),
        .o_ctr_we     (ctr_we),
        .o_ctr_waddr  (ctr_waddr),
        .o_ctr_wdata  (ctr_wdata),
        .o_ctr_re     (ctr_re),
        .o_ctr_raddr  (ctr_raddr),
        .i_ctr_rdata  (ctr_rdata),
        .o_res        (res),
        .i_res_free   (res_free)
    );

    // result register
    tllbp_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (res),
        .o_free     (res_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire

>>> design/tllbp_ram.sv
// generic single-write, single-read synchronous ram with registered read data
`default_nettype none

module tllbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/tllbp_ctrl.sv
// sequencer: clearing pass, history read, counter read, then write-back or result
`default_nettype none

module tllbp_ctrl import tllbp_pkg::*; #(
    parameter int HIST_BITS = HIST_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // request side
    input  wire logic                            i_req_valid,
    output logic                                 o_req_ready,
    input  wire logic                            i_req_type,
    input  wire logic [PC_W-1:0]                 i_pc,
    input  wire logic                            i_dir,
    // history ram
    output logic                                 o_hist_we,
    output logic      [HIDX_BITS-1:0]            o_hist_waddr,
    output logic      [HIST_BITS-1:0]            o_hist_wdata,
    output logic                                 o_hist_re,
    output logic      [HIDX_BITS-1:0]            o_hist_raddr,
    input  wire logic [HIST_BITS-1:0]            i_hist_rdata,
    // counter ram
    output logic                                 o_ctr_we,
    output logic      [TABLE_BITS+HIST_BITS-1:0] o_ctr_waddr,
    output logic      [1:0]                      o_ctr_wdata,
    output logic                                 o_ctr_re,
    output logic      [TABLE_BITS+HIST_BITS-1:0] o_ctr_raddr,
    input  wire logic [1:0]                      i_ctr_rdata,
    // result side
    output t_res                                 o_res,
    input  wire logic                            i_res_free
);

    localparam int CTR_AW = TABLE_BITS + HIST_BITS;
    localparam int CLR_AW = (CTR_AW > HIDX_BITS) ? CTR_AW : HIDX_BITS;

    t_state                r_state, n_state;
    logic [CLR_AW-1:0]     r_clr_addr, n_clr_addr;
    logic                  r_req;
    logic [TABLE_BITS-1:0] r_tbl;
    logic [HIDX_BITS-1:0]  r_hidx;
    logic                  r_dir;
    logic [HIST_BITS-1:0]  r_hist;

    logic                  accept;
    logic [HIST_BITS:0]    hist_shift;
    logic [1:0]            ctr_next;

    assign accept = (r_state == S_IDLE) && i_req_valid;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    // request fields captured at accept, history captured after its read
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req_type;
            r_tbl  <= i_pc[TABLE_BITS-1:0];
            r_hidx <= i_pc[TABLE_BITS+HIDX_BITS-1:TABLE_BITS];
            r_dir  <= i_dir;
        end
        if (r_state == S_HIST) begin
            r_hist <= i_hist_rdata;
        end
    end

    // new history and saturating counter
    assign hist_shift = {r_hist, r_dir};

    always_comb begin
        if (r_dir) begin
            ctr_next = (i_ctr_rdata == CTR_MAX) ? CTR_MAX : i_ctr_rdata + 2'd1;
        end else begin
            ctr_next = (i_ctr_rdata == CTR_MIN) ? CTR_MIN : i_ctr_rdata - 2'd1;
        end
    end

    // next state and ram controls
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        o_req_ready  = 1'b0;
        o_hist_we    = 1'b0;
        o_hist_waddr = r_hidx;
        o_hist_wdata = hist_shift[HIST_BITS-1:0];
        o_hist_re    = 1'b0;
        o_hist_raddr = i_pc[TABLE_BITS+HIDX_BITS-1:TABLE_BITS];
        o_ctr_we     = 1'b0;
        o_ctr_waddr  = {r_tbl, r_hist};
        o_ctr_wdata  = ctr_next;
        o_ctr_re     = 1'b0;
        o_ctr_raddr  = {r_tbl, i_hist_rdata};
        o_res.valid  = 1'b0;
        o_res.taken  = (i_ctr_rdata >= CTR_WEAK_T);
        unique case (r_state)
            S_CLEAR: begin
                o_hist_we    = 1'b1;
                o_hist_waddr = r_clr_addr[HIDX_BITS-1:0];
                o_hist_wdata = '0;
                o_ctr_we     = 1'b1;
                o_ctr_waddr  = r_clr_addr[CTR_AW-1:0];
                o_ctr_wdata  = CTR_WEAK_NT;
                n_clr_addr   = r_clr_addr + 1'b1;
                if (r_clr_addr == {CLR_AW{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_hist_re = 1'b1;
                    n_state   = S_HIST;
                end
            end
            S_HIST: begin
                o_ctr_re = 1'b1;
                n_state  = S_CTR;
            end
            S_CTR: begin
                if (r_req == REQ_TRAIN) begin
                    o_hist_we = 1'b1;
                    o_ctr_we  = 1'b1;
                    n_state   = S_IDLE;
                end else if (i_res_free) begin
                    o_res.valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/tllbp_out.sv
// output register for predictions, takes a new one while the old is drained
`default_nettype none

module tllbp_out import tllbp_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_res                 i_res,
    output logic                      o_free,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic      [M_TDATA_W-1:0] o_m_tdata
);

    logic r_valid;
    logic r_taken;

    assign o_free = !r_valid || i_m_tready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res.valid) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_taken <= i_res.taken;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{(M_TDATA_W-1){1'b0}}, r_taken};

endmodule

`default_nettype wire

>>> design/tllbp_checker.sv
// port-level checks of the local branch predictor, bound to the top level
`default_nettype none

`include "two_level_local_branch_predictor_assert.svh"

module tllbp_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_s_tvalid,
    input wire logic o_s_tready,
    input wire logic o_m_tvalid,
    input wire logic i_m_tready
);

    // a stalled prediction is not dropped
    `TLLBP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid)

    // leaving reset starts the clearing pass with nothing pending
    `TLLBP_ASSERT_SAME(a_clear_start, i_clk, i_rst_n, $rose(i_rst_n), !o_s_tready && !o_m_tvalid)

    // one request at a time: busy right after a transaction
    `TLLBP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

endmodule

bind two_level_local_branch_predictor tllbp_checker u_tllbp_checker (.*);

`default_nettype wire
